// File: design/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared constants and types for the heap sort block: store geometry and the
// request bundle between the control logic and the heap store.
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // child indexes reach 2*(DEPTH-1)+2
  localparam int IDX_W  = $clog2(2 * DEPTH + 1);
  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] word_t;

  // one write port, two read ports
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    word_t             wdata;
    logic [ADDR_W-1:0] ra_addr;
    logic [ADDR_W-1:0] rb_addr;
  } hsd_ram_req_t;

endpackage

// File: design/hsd_ram.sv
// ----------------------------------------------------------------------------
// hsd_ram
// Heap store: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module hsd_ram
  import hsd_pkg::*;
(
  input  logic         clk,
  input  hsd_ram_req_t req,
  output word_t        ra_data,
  output word_t        rb_data
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    ra_data <= mem[req.ra_addr];
    rb_data <= mem[req.rb_addr];
  end

endmodule

// File: design/heap_sort_descending_unit.sv
// ----------------------------------------------------------------------------
// heap_sort_descending_unit
// Collects a list of signed words, heap-sorts it in place in a memory and
// streams it back largest first.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                    | tlast        | tuser
//  --------+-----+--------------------------+--------------+---------
//  in_     | in  | [31:0] value             | last         | -
//  out_    | out | [31:0] sorted_value      | end_of_list  | dropped
//
//  Loading accepts one request per cycle. Once the last request arrives the
//  heap is built bottom-up, then each result takes an emit step plus a
//  sift-down: a fetch and a load step bring in the moving value, then one
//  compare step per heap level (up to log2(DEPTH)) moves the hole down.
//  The sift steps are set by the two-read, one-write heap memory.
//  Reset (rst_n low, synchronous) empties the list; the memory is not cleared.
//  A stalled output holds its result; the next sift-down runs on, then the
//  sort waits in the emit step until the result is taken.
//  No new request is taken between the last request and the final result.
// ----------------------------------------------------------------------------
module heap_sort_descending_unit
  import hsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,  // end_of_list
  output logic        out_tuser   // [0] dropped
);

  typedef enum logic [5:0] {
    S_COLLECT = 6'b000001,
    S_FETCH   = 6'b000010,
    S_LOAD    = 6'b000100,
    S_CMP     = 6'b001000,
    S_PUT     = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;     // elements held
  logic              ovf_r, ovf_nxt;         // an element was discarded
  logic [CNT_W-1:0]  size_r, size_nxt;       // current heap size
  logic              build_r, build_nxt;     // building, not extracting
  logic [ADDR_W-1:0] src_r, src_nxt;         // address of the moving value
  logic [ADDR_W-1:0] hole_r, hole_nxt;       // current hole position
  word_t             mv_r, mv_nxt;           // value being sifted down
  word_t             root_r, root_nxt;       // copy of heap entry 0
  logic              out_valid_r, out_valid_nxt;
  word_t             out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_drop_r, out_drop_nxt;

  hsd_ram_req_t      ram_req;
  word_t             ra_data, rb_data;

  logic              in_acc;
  logic              has_room;
  logic [CNT_W-1:0]  n_new;
  logic [IDX_W-1:0]  size_x;
  logic [IDX_W-1:0]  c_idx;        // left child of the hole
  logic [IDX_W-1:0]  big_idx;
  logic [IDX_W-1:0]  nc_idx;       // left child of the winning child
  logic              take_right;
  word_t             big_val;
  word_t             load_val;
  logic              sift_done;
  logic              emit_go;

  hsd_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  assign in_tready  = (state_r == S_COLLECT);
  assign in_acc     = in_tvalid && in_tready;
  assign has_room   = (count_r < CNT_W'(DEPTH));
  assign n_new      = has_room ? count_r + CNT_W'(1) : count_r;

  assign size_x     = IDX_W'(size_r);
  assign c_idx      = {hole_r, 1'b1} + IDX_W'(0);
  assign take_right = ((c_idx + IDX_W'(1)) < size_x) && (rb_data > ra_data);
  assign big_val    = take_right ? rb_data : ra_data;
  assign big_idx    = take_right ? c_idx + IDX_W'(1) : c_idx;
  assign nc_idx     = {big_idx[IDX_W-2:0], 1'b1};
  assign load_val   = ra_data;

  assign emit_go    = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    size_nxt      = size_r;
    build_nxt     = build_r;
    src_nxt       = src_r;
    hole_nxt      = hole_r;
    mv_nxt        = mv_r;
    root_nxt      = root_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    out_valid_nxt = out_valid_r && !out_tready;
    sift_done     = 1'b0;
    ram_req       = '{we: 1'b0, waddr: hole_r, wdata: mv_r,
                      ra_addr: src_r, rb_addr: src_r};

    case (state_r)
      S_COLLECT: begin
        ram_req.waddr = count_r[ADDR_W-1:0];
        ram_req.wdata = word_t'(in_tdata);
        if (in_acc) begin
          if (has_room) begin
            ram_req.we = 1'b1;
            count_nxt  = n_new;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            size_nxt = n_new;
            // first internal node is n/2 - 1; a single element is already a heap
            if ((n_new >> 1) == CNT_W'(0)) begin
              build_nxt = 1'b0;
              state_nxt = S_EMIT;
            end else begin
              build_nxt = 1'b1;
              src_nxt   = ADDR_W'((n_new >> 1) - CNT_W'(1));
              hole_nxt  = ADDR_W'((n_new >> 1) - CNT_W'(1));
              state_nxt = S_FETCH;
            end
          end
        end
      end

      S_FETCH: begin
        ram_req.ra_addr = src_r;
        state_nxt       = S_LOAD;
      end

      S_LOAD: begin
        mv_nxt          = load_val;
        ram_req.ra_addr = c_idx[ADDR_W-1:0];
        ram_req.rb_addr = ADDR_W'(c_idx + IDX_W'(1));
        if (c_idx >= size_x) begin
          // leaf: drop the moving value back into the hole
          ram_req.we    = 1'b1;
          ram_req.wdata = load_val;
          sift_done     = 1'b1;
        end else begin
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        ram_req.ra_addr = nc_idx[ADDR_W-1:0];
        ram_req.rb_addr = ADDR_W'(nc_idx + IDX_W'(1));
        ram_req.we      = 1'b1;
        if (big_val > mv_r) begin
          // promote the larger child, advance the hole
          ram_req.wdata = big_val;
          hole_nxt      = big_idx[ADDR_W-1:0];
          if (nc_idx >= size_x) begin
            state_nxt = S_PUT;
          end
        end else begin
          ram_req.wdata = mv_r;
          sift_done     = 1'b1;
        end
      end

      S_PUT: begin
        ram_req.we = 1'b1;
        sift_done  = 1'b1;
      end

      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = root_r;
          out_last_nxt  = (size_r == CNT_W'(1));
          out_drop_nxt  = ovf_r;
          if (size_r == CNT_W'(1)) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_COLLECT;
          end else begin
            // move the last leaf to the root and sift it down
            size_nxt  = size_r - CNT_W'(1);
            src_nxt   = ADDR_W'(size_r - CNT_W'(1));
            hole_nxt  = '0;
            state_nxt = S_FETCH;
          end
        end
      end

      default: begin
        state_nxt = S_COLLECT;
      end
    endcase

    if (sift_done) begin
      if (build_r && (src_r != '0)) begin
        src_nxt   = src_r - ADDR_W'(1);
        hole_nxt  = src_r - ADDR_W'(1);
        state_nxt = S_FETCH;
      end else begin
        build_nxt = 1'b0;
        state_nxt = S_EMIT;
      end
    end

    // track the root so a result needs no extra read
    if (ram_req.we && (ram_req.waddr == '0)) begin
      root_nxt = ram_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      build_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      build_r     <= build_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    src_r      <= src_nxt;
    hole_r     <= hole_nxt;
    mv_r       <= mv_nxt;
    root_r     <= root_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 32'(out_data_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_drop_r;

endmodule

// File: design/hsd_checker.sv
// ----------------------------------------------------------------------------
// hsd_checker
// Port-level checks for the heap sort block, bound to the top level.
// ----------------------------------------------------------------------------
module hsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // the input is not ready right after the last request
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("request taken right after end of list");

  // no result leaves the block right after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind heap_sort_descending_unit hsd_checker u_hsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
